// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescaper.
package jsu_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_DATA       = 2'd0;
    localparam logic [1:0] KIND_DONE       = 2'd1;
    localparam logic [1:0] KIND_INCOMPLETE = 2'd2;

    // Decoupling queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Work record for one input word: emitted in the order cp0, cp1, tail.
    // cp0 is always a flushed high surrogate, so only its low ten bits travel.
    typedef struct packed {
        logic        cp0_vld;
        logic [9:0]  cp0_low;
        logic        cp1_vld;
        logic [20:0] cp1;
        logic        tail_vld;
        logic [7:0]  tail_byte;
        logic [1:0]  tail_kind;
    } jsu_rec_t;

endpackage

// ===== rtl/jsu_front.sv =====
// Front end: parses input words, tracks escape state, builds work records.
module jsu_front
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     q_full,
    input  logic     end_of_data,
    input  logic [7:0] in_byte,
    output logic     in_ready,
    output logic     push,
    output jsu_rec_t push_rec
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_HEX,
        MODE_HIGH,
        MODE_HIGH_BS
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_U      = 8'h75;

    mode_t       mode_reg,     mode_next;
    logic [15:0] hex_val_reg,  hex_val_next;
    logic [1:0]  hex_cnt_reg,  hex_cnt_next;
    logic [9:0]  held_reg,     held_next;
    logic        held_vld_reg, held_vld_next;

    logic        accept;
    logic        dig_vld;
    logic [3:0]  dig;
    logic [15:0] cp;
    logic        do_finish;
    logic        run_plain;
    logic        run_escape;
    jsu_rec_t    rec;

    // Simple escapes map to one byte; unknown ones copy the byte itself.
    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] r;
        unique case (b)
            8'h62:   r = 8'h08;  // b
            8'h74:   r = 8'h09;  // t
            8'h6e:   r = 8'h0a;  // n
            8'h66:   r = 8'h0c;  // f
            8'h72:   r = 8'h0d;  // r
            default: r = b;
        endcase
        return r;
    endfunction

    assign in_ready = !q_full;
    assign accept   = in_valid && !q_full;

    always_comb
    begin
        dig_vld = 1'b0;
        dig     = in_byte[3:0];
        if (in_byte >= 8'h30 && in_byte <= 8'h39)
        begin
            dig_vld = 1'b1;
        end
        else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46))
        begin
            dig_vld = 1'b1;
            dig     = in_byte[3:0] + 4'd9;
        end
    end

    always_comb
    begin
        mode_next     = mode_reg;
        hex_val_next  = hex_val_reg;
        hex_cnt_next  = hex_cnt_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        rec           = '0;
        do_finish     = 1'b0;
        run_plain     = 1'b0;
        run_escape    = 1'b0;
        cp            = hex_val_reg;

        if (end_of_data)
        begin
            rec.tail_vld  = 1'b1;
            rec.tail_kind = KIND_INCOMPLETE;
            mode_next     = MODE_PLAIN;
            hex_val_next  = '0;
            hex_cnt_next  = '0;
            held_next     = '0;
            held_vld_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_ESC:
                begin
                    run_escape = 1'b1;
                end
                MODE_HEX:
                begin
                    if (dig_vld)
                    begin
                        cp = {hex_val_reg[11:0], dig};
                        hex_val_next = cp;
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                        do_finish    = (hex_cnt_reg == 2'd3);
                    end
                    else
                    begin
                        do_finish = 1'b1;
                    end
                end
                MODE_HIGH:
                begin
                    if (in_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_HIGH_BS;
                    end
                    else
                    begin
                        rec.cp0_vld   = 1'b1;
                        rec.cp0_low   = held_reg;
                        held_next     = '0;
                        held_vld_next = 1'b0;
                        run_plain     = 1'b1;
                    end
                end
                MODE_HIGH_BS:
                begin
                    if (in_byte == CH_U)
                    begin
                        mode_next    = MODE_HEX;
                        hex_val_next = '0;
                        hex_cnt_next = '0;
                    end
                    else
                    begin
                        rec.cp0_vld   = 1'b1;
                        rec.cp0_low   = held_reg;
                        held_next     = '0;
                        held_vld_next = 1'b0;
                        run_escape    = 1'b1;
                    end
                end
                default:
                begin
                    run_plain = 1'b1;
                end
            endcase

            // End of a \u escape: pair, hold or emit the code point.
            if (do_finish)
            begin
                hex_val_next = '0;
                hex_cnt_next = '0;
                if (held_vld_reg && cp >= 16'hdc00 && cp <= 16'hdfff)
                begin
                    rec.cp1_vld   = 1'b1;
                    rec.cp1       = {1'b0, held_reg, cp[9:0]} + 21'h10000;
                    held_next     = '0;
                    held_vld_next = 1'b0;
                    mode_next     = MODE_PLAIN;
                end
                else
                begin
                    rec.cp0_vld = held_vld_reg;
                    rec.cp0_low = held_reg;
                    if (cp >= 16'hd800 && cp <= 16'hdbff)
                    begin
                        held_next     = cp[9:0];
                        held_vld_next = 1'b1;
                        mode_next     = MODE_HIGH;
                    end
                    else
                    begin
                        held_next     = '0;
                        held_vld_next = 1'b0;
                        rec.cp1_vld   = (cp != 16'h0);
                        rec.cp1       = {5'd0, cp};
                        mode_next     = MODE_PLAIN;
                    end
                end
                // A non-hex byte ended the escape early; it is then handled
                // as if it followed, which may flush a surrogate just held.
                if (!dig_vld)
                begin
                    if (mode_next == MODE_HIGH)
                    begin
                        if (in_byte == CH_BSLASH)
                        begin
                            mode_next = MODE_HIGH_BS;
                        end
                        else
                        begin
                            rec.cp1_vld   = 1'b1;
                            rec.cp1       = {5'd0, 6'b110110, cp[9:0]};
                            held_next     = '0;
                            held_vld_next = 1'b0;
                            run_plain     = 1'b1;
                        end
                    end
                    else
                    begin
                        run_plain = 1'b1;
                    end
                end
            end

            if (run_plain)
            begin
                if (in_byte == CH_QUOTE)
                begin
                    rec.tail_vld  = 1'b1;
                    rec.tail_kind = KIND_DONE;
                    mode_next     = MODE_PLAIN;
                    hex_val_next  = '0;
                    hex_cnt_next  = '0;
                    held_next     = '0;
                    held_vld_next = 1'b0;
                end
                else if (in_byte == CH_BSLASH)
                begin
                    mode_next = MODE_ESC;
                end
                else
                begin
                    rec.tail_vld  = 1'b1;
                    rec.tail_byte = in_byte;
                    rec.tail_kind = KIND_DATA;
                    mode_next     = MODE_PLAIN;
                end
            end

            if (run_escape)
            begin
                if (in_byte == CH_U)
                begin
                    mode_next    = MODE_HEX;
                    hex_val_next = '0;
                    hex_cnt_next = '0;
                end
                else
                begin
                    rec.tail_vld  = 1'b1;
                    rec.tail_byte = esc_map(in_byte);
                    rec.tail_kind = KIND_DATA;
                    mode_next     = MODE_PLAIN;
                end
            end
        end
    end

    assign push     = accept && (rec.cp0_vld || rec.cp1_vld || rec.tail_vld);
    assign push_rec = rec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_PLAIN;
            hex_val_reg  <= '0;
            hex_cnt_reg  <= '0;
            held_reg     <= '0;
            held_vld_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg     <= mode_next;
            hex_val_reg  <= hex_val_next;
            hex_cnt_reg  <= hex_cnt_next;
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
        end
    end

`ifndef SYNTHESIS
    // A held high surrogate exists in the surrogate-follow modes and never in plain or escape mode.
    a_held_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_HIGH || mode_reg == MODE_HIGH_BS) |-> held_vld_reg)
        else $error("surrogate mode without held surrogate");
    a_held_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_PLAIN || mode_reg == MODE_ESC) |-> !held_vld_reg)
        else $error("held surrogate left in plain mode");
`endif

endmodule

// ===== rtl/jsu_queue.sv =====
// Short FIFO of work records between the front and back ends.
module jsu_queue
    import jsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  jsu_rec_t push_rec,
    input  logic     pop,
    output logic     full,
    output logic     head_vld,
    output jsu_rec_t head_rec
);

    jsu_rec_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg;
    logic [Q_AW-1:0]   rd_ptr_reg;
    logic [Q_CW-1:0]   count_reg, count_next;
    logic              do_pop;

    assign full     = (count_reg == Q_CW'(Q_DEPTH));
    assign head_vld = (count_reg != '0);
    assign head_rec = mem_reg[rd_ptr_reg];
    assign do_pop   = pop && head_vld;

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + Q_CW'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - Q_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("record pushed into full queue");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != Q_CW'(Q_DEPTH)) |-> (wr_ptr_reg - rd_ptr_reg) == count_reg[Q_AW-1:0])
        else $error("queue pointers disagree with fill count");
`endif

endmodule

// ===== rtl/jsu_back.sv =====
// Back end: expands a work record into UTF-8 words and streams them out.
module jsu_back
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_vld,
    input  jsu_rec_t   head_rec,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [1:0] out_kind,
    output logic       out_last
);

    typedef struct packed {
        logic [7:0][7:0] bytes;
        logic [7:0][1:0] kinds;
        logic [3:0]      cnt;
    } list_t;

    list_t      list_reg, list_next;
    logic [2:0] idx_reg,  idx_next;
    logic       busy_reg, busy_next;
    logic       take;

    // Lay the record out as up to eight candidate words, then pack them.
    function automatic list_t expand(input jsu_rec_t r);
        logic [7:0][7:0] cb;
        logic [7:0][1:0] ck;
        logic [7:0]      cv;
        logic [20:0]     c;
        list_t           l;
        logic [3:0]      n;
        c  = r.cp1;
        cb = '0;
        ck = {8{KIND_DATA}};
        cv = '0;
        l  = '0;
        n  = '0;
        // flushed high surrogate, always three bytes
        cb[0] = 8'hed;
        cb[1] = {4'b1010, r.cp0_low[9:6]};
        cb[2] = {2'b10, r.cp0_low[5:0]};
        cv[2:0] = {3{r.cp0_vld}};
        if (c < 21'h80)
        begin
            cb[3] = {1'b0, c[6:0]};
            cv[3] = r.cp1_vld;
        end
        else if (c < 21'h800)
        begin
            cb[3] = {3'b110, c[10:6]};
            cb[4] = {2'b10, c[5:0]};
            cv[4:3] = {2{r.cp1_vld}};
        end
        else if (c < 21'h10000)
        begin
            cb[3] = {4'b1110, c[15:12]};
            cb[4] = {2'b10, c[11:6]};
            cb[5] = {2'b10, c[5:0]};
            cv[5:3] = {3{r.cp1_vld}};
        end
        else
        begin
            cb[3] = {5'b11110, c[20:18]};
            cb[4] = {2'b10, c[17:12]};
            cb[5] = {2'b10, c[11:6]};
            cb[6] = {2'b10, c[5:0]};
            cv[6:3] = {4{r.cp1_vld}};
        end
        cb[7] = r.tail_byte;
        ck[7] = r.tail_kind;
        cv[7] = r.tail_vld;
        for (int i = 0; i < 8; i++)
        begin
            if (cv[i])
            begin
                l.bytes[n[2:0]] = cb[i];
                l.kinds[n[2:0]] = ck[i];
                n = n + 4'd1;
            end
        end
        l.cnt = n;
        return l;
    endfunction

    assign out_valid = busy_reg;
    assign out_byte  = list_reg.bytes[idx_reg];
    assign out_kind  = list_reg.kinds[idx_reg];
    assign out_last  = (({1'b0, idx_reg} + 4'd1) == list_reg.cnt);

    // Load the next record when idle or when the final word is taken.
    assign take = !busy_reg || (out_ready && out_last);
    assign pop  = take && head_vld;

    always_comb
    begin
        list_next = list_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (take)
        begin
            busy_next = head_vld;
            idx_next  = '0;
            if (head_vld)
            begin
                list_next = expand(head_rec);
            end
        end
        else if (out_ready)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        list_reg <= list_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, idx_reg} < list_reg.cnt))
        else $error("word index past end of list");
    a_pop_on_take: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && out_ready && !out_last) |-> !pop)
        else $error("record loaded while list still draining");
`endif

endmodule

// ===== rtl/json_string_unescaper_core.sv =====
// Top level of the JSON string unescaper: front parser, queue, UTF-8 emitter.
//
// Takes the body of a JSON string one byte per word, starting after the
// opening quote, and emits the decoded UTF-8 bytes one per word. Plain bytes
// pass through; \\ \" \b \t \n \f \r map to their byte; other escapes copy the
// byte after the backslash; \u reads up to four hex digits and emits the code
// point as UTF-8 (code point zero emits nothing), pairing a high surrogate
// with an immediately following \u low surrogate and otherwise emitting the
// lone surrogate as three bytes. An unescaped quote gives a word of kind
// "complete"; an input word with end_of_data set gives a word of kind
// "incomplete" and resets the parser. tlast marks the final output word
// caused by an input word; input words that cause nothing (a backslash, a hex
// digit, a held surrogate) produce no output.
// Rate: one input word per cycle while the record queue has room, and one
// output word per cycle while m_axis_tready is high. An input word may
// expand into n output words (n is at most 7); a 4-deep record queue between
// the parser and the UTF-8 emitter absorbs these bursts, and s_axis_tready
// drops only when it fills. Records pass the queue, then the list register.
module json_string_unescaper_core
    import jsu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tuser,   // [0] end_of_data
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] kind
    output logic       m_axis_tlast    // last word caused by one input word
);

    logic     q_full;
    logic     q_push;
    jsu_rec_t q_push_rec;
    logic     q_pop;
    logic     q_head_vld;
    jsu_rec_t q_head_rec;

    // Parser: escape state machine and surrogate holding.
    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .q_full      (q_full),
        .end_of_data (s_axis_tuser),
        .in_byte     (s_axis_tdata),
        .in_ready    (s_axis_tready),
        .push        (q_push),
        .push_rec    (q_push_rec)
    );

    // Records wait here so the parser keeps going while output stalls.
    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (q_push_rec),
        .pop      (q_pop),
        .full     (q_full),
        .head_vld (q_head_vld),
        .head_rec (q_head_rec)
    );

    // UTF-8 encoder and output word sequencer.
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_vld  (q_head_vld),
        .head_rec  (q_head_rec),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_kind  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
